// ----- src/ptm_pkg.sv -----
package ptm_pkg;

	// tone curve codes
	localparam logic [1:0] CURVE_ACES     = 2'd0;
	localparam logic [1:0] CURVE_REINHARD = 2'd1;
	localparam logic [1:0] CURVE_FILMIC   = 2'd2;

	// datapath widths
	localparam int XW = 15;  // curve operand, filmic q up to 25432
	localparam int AW = 21;  // linear terms, up to 1865784
	localparam int CW = 28;  // constant term, up to 173400000
	localparam int DW = 36;  // products and denominator
	localparam int NW = 44;  // numerator scaled by 255

	typedef struct packed {
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
		logic       last_pixel;
	} ptm_in_t;

	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic       last_pixel_out;
	} ptm_out_t;

	// one restoring division step: {quotient bit, new remainder}
	function automatic logic [NW:0] div_step(input logic [NW-1:0] r, input logic [NW-1:0] ds);
		logic [NW:0] res;
		if (r >= ds) begin
			res = {1'b1, r - ds};
		end else begin
			res = {1'b0, r};
		end
		return res;
	endfunction

endpackage

// ----- src/ptm_channel.sv -----
module ptm_channel (
	input  logic       clk,
	input  logic       en,
	input  logic [1:0] curve,
	input  logic [7:0] p,
	output logic [7:0] y
);

	logic [ptm_pkg::XW-1:0] x_c, x_s1;
	logic [ptm_pkg::AW-1:0] a_c, b_c, a_s1, b_s1;
	logic [ptm_pkg::CW-1:0] c_c, c_s1;
	logic [ptm_pkg::DW-1:0] m1_s2, m2_s2;
	logic [ptm_pkg::NW-1:0] n_s3;
	logic [ptm_pkg::DW-1:0] d_s3, d_s4, d_s5, d_s6;
	logic [ptm_pkg::NW-1:0] r_s4, r_s5, r_s6;
	logic                   sat_s4, sat_s5, sat_s6, sat_s7;
	logic [1:0]             q_s4;
	logic [3:0]             q_s5;
	logic [5:0]             q_s6;
	logic [7:0]             q_s7;
	logic [ptm_pkg::NW:0]   st4a, st4b, st5a, st5b, st6a, st6b, st7a, st7b;
	logic [ptm_pkg::NW-1:0] dw3, dw4, dw5, dw6;
	logic [ptm_pkg::XW-1:0] qf;

	// curve operands: out = 255*x*a / (x*b + c)
	always_comb begin
		qf = (p == 8'd0) ? '0 : (ptm_pkg::XW'(p) * 15'd100 - 15'd68);
		case (curve)
			ptm_pkg::CURVE_REINHARD: begin
				x_c = ptm_pkg::XW'(p);
				a_c = 21'd1;
				b_c = 21'd1;
				c_c = 28'd170;
			end
			ptm_pkg::CURVE_FILMIC: begin
				x_c = qf;
				a_c = ptm_pkg::AW'(qf) * 21'd62 + 21'd85000;
				b_c = ptm_pkg::AW'(qf) * 21'd62 + 21'd289000;
				c_c = 28'd173400000;
			end
			default: begin
				x_c = ptm_pkg::XW'(p);
				a_c = ptm_pkg::AW'(p) * 21'd251 + 21'd510;
				b_c = ptm_pkg::AW'(p) * 21'd243 + 21'd10030;
				c_c = 28'd404600;
			end
		endcase
	end

	// denominators widened for the divide steps
	assign dw3 = ptm_pkg::NW'(d_s3);
	assign dw4 = ptm_pkg::NW'(d_s4);
	assign dw5 = ptm_pkg::NW'(d_s5);
	assign dw6 = ptm_pkg::NW'(d_s6);

	assign st4a = ptm_pkg::div_step(n_s3, dw3 << 7);
	assign st4b = ptm_pkg::div_step(st4a[ptm_pkg::NW-1:0], dw3 << 6);
	assign st5a = ptm_pkg::div_step(r_s4, dw4 << 5);
	assign st5b = ptm_pkg::div_step(st5a[ptm_pkg::NW-1:0], dw4 << 4);
	assign st6a = ptm_pkg::div_step(r_s5, dw5 << 3);
	assign st6b = ptm_pkg::div_step(st6a[ptm_pkg::NW-1:0], dw5 << 2);
	assign st7a = ptm_pkg::div_step(r_s6, dw6 << 1);
	assign st7b = ptm_pkg::div_step(st7a[ptm_pkg::NW-1:0], dw6);

	// pipeline: operands, products, scale, four two-bit divide stages
	always_ff @(posedge clk) begin
		if (en) begin
			x_s1   <= x_c;
			a_s1   <= a_c;
			b_s1   <= b_c;
			c_s1   <= c_c;
			m1_s2  <= ptm_pkg::DW'(x_s1) * ptm_pkg::DW'(a_s1);
			m2_s2  <= ptm_pkg::DW'(x_s1) * ptm_pkg::DW'(b_s1) + ptm_pkg::DW'(c_s1);
			n_s3   <= (ptm_pkg::NW'(m1_s2) << 8) - ptm_pkg::NW'(m1_s2);
			d_s3   <= m2_s2;
			sat_s4 <= n_s3 >= (dw3 << 8);
			q_s4   <= {st4a[ptm_pkg::NW], st4b[ptm_pkg::NW]};
			r_s4   <= st4b[ptm_pkg::NW-1:0];
			d_s4   <= d_s3;
			sat_s5 <= sat_s4;
			q_s5   <= {q_s4, st5a[ptm_pkg::NW], st5b[ptm_pkg::NW]};
			r_s5   <= st5b[ptm_pkg::NW-1:0];
			d_s5   <= d_s4;
			sat_s6 <= sat_s5;
			q_s6   <= {q_s5, st6a[ptm_pkg::NW], st6b[ptm_pkg::NW]};
			r_s6   <= st6b[ptm_pkg::NW-1:0];
			d_s6   <= d_s5;
			sat_s7 <= sat_s6;
			q_s7   <= {q_s6, st7a[ptm_pkg::NW], st7b[ptm_pkg::NW]};
		end
	end

	assign y = sat_s7 ? 8'hFF : q_s7;

endmodule

// ----- src/pixel_tone_mapper.sv -----
// Tone maps one RGB pixel per clock with a fixed 1.5 exposure and a selectable
// curve (ACES fitted, Reinhard or filmic), exact integer arithmetic, results
// truncated and saturated to bytes. The pipeline runs through operand setup,
// two products per channel, scaling and four stages of a two-bit-per-stage
// restoring divider; throughput is one pixel every cycle while not stalled.
// The whole pipeline holds when the output is stalled. curve_select is
// written through the cfg channel and should only change while no pixel is
// in flight.
module pixel_tone_mapper (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  ptm_pkg::ptm_in_t  in_data,
	output logic              out_valid,
	input  logic              out_ready,
	output ptm_pkg::ptm_out_t out_data,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_data
);

	localparam int STAGES = 7;

	logic [1:0]        curve_q;
	logic [STAGES-1:0] vld_q;
	logic [STAGES-1:0] last_q;
	logic              en;

	// pipeline moves when the output stage is empty or being taken
	assign en        = !vld_q[STAGES-1] || out_ready;
	assign in_ready  = en;
	assign out_valid = vld_q[STAGES-1];
	assign cfg_ready = 1'b1;

	// curve register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			curve_q <= ptm_pkg::CURVE_ACES;
		end else if (cfg_valid) begin
			curve_q <= cfg_data;
		end
	end

	// valid bits travel with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[STAGES-2:0], in_valid};
		end
	end

	// frame end marker delay line
	always_ff @(posedge clk) begin
		if (en) begin
			last_q <= {last_q[STAGES-2:0], in_data.last_pixel};
		end
	end

	ptm_channel u_red (
		.clk(clk), .en(en), .curve(curve_q), .p(in_data.red_in), .y(out_data.red_out)
	);
	ptm_channel u_green (
		.clk(clk), .en(en), .curve(curve_q), .p(in_data.green_in), .y(out_data.green_out)
	);
	ptm_channel u_blue (
		.clk(clk), .en(en), .curve(curve_q), .p(in_data.blue_in), .y(out_data.blue_out)
	);

	assign out_data.last_pixel_out = last_q[STAGES-1];

`ifndef SYNTH
	// a stalled full output blocks new input
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !in_ready)
		else $error("input accepted while output stalled");

	// an accepted pixel occupies the first stage
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> vld_q[0])
		else $error("accepted pixel lost at entry");

	// Reinhard never exceeds 153
	a_reinhard_max: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && curve_q == ptm_pkg::CURVE_REINHARD) |->
		(out_data.red_out <= 8'd153 && out_data.green_out <= 8'd153 &&
		 out_data.blue_out <= 8'd153))
		else $error("Reinhard output out of range");
`endif

endmodule

// ----- tb/ptm_checker.sv -----
`timescale 1ns / 1ps

module ptm_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  logic              in_ready,
	input  ptm_pkg::ptm_in_t  in_data,
	input  logic              out_valid,
	input  logic              out_ready,
	input  ptm_pkg::ptm_out_t out_data,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [1:0]        cfg_data,
	output int                fail_count,
	output int                pending_count
);

	logic [1:0]        curve_sel;
	ptm_pkg::ptm_out_t expected_pixels[$];

	// exact rational tone curve for one channel byte
	function automatic logic [7:0] tone_map(input logic [7:0] p, input logic [1:0] sel);
		longint unsigned x, q, num, den, r;
		x = p;
		if (sel == ptm_pkg::CURVE_REINHARD) begin
			r = (255 * x) / (170 + x);
		end else if (sel == ptm_pkg::CURVE_FILMIC) begin
			q = (100 * x > 68) ? 100 * x - 68 : 0;
			num = q * (62 * q + 85000);
			den = q * (62 * q + 289000) + 173400000;
			r = (255 * num) / den;
		end else begin
			// ACES, also for the unused code
			num = x * (251 * x + 510);
			den = x * (243 * x + 10030) + 404600;
			r = (255 * num) / den;
		end
		if (r > 255) r = 255;
		return r[7:0];
	endfunction

	always @(posedge clk or negedge arst_n) begin
		ptm_pkg::ptm_out_t e;
		int errs;
		if (!arst_n) begin
			curve_sel <= ptm_pkg::CURVE_ACES;
			fail_count <= 0;
			pending_count <= 0;
			expected_pixels.delete();
		end else begin
			errs = 0;
			if (cfg_valid && cfg_ready) curve_sel <= cfg_data;
			// predict on input transfer
			if (in_valid && in_ready) begin
				e.red_out = tone_map(in_data.red_in, curve_sel);
				e.green_out = tone_map(in_data.green_in, curve_sel);
				e.blue_out = tone_map(in_data.blue_in, curve_sel);
				e.last_pixel_out = in_data.last_pixel;
				expected_pixels.push_back(e);
			end
			// compare on output transfer
			if (out_valid && out_ready) begin
				if (expected_pixels.size() == 0) begin
					$error("unexpected output pixel %h", out_data);
					errs++;
				end else begin
					e = expected_pixels.pop_front();
					if (out_data.red_out !== e.red_out) begin
						$error("red_out exp %0d got %0d", e.red_out, out_data.red_out);
						errs++;
					end
					if (out_data.green_out !== e.green_out) begin
						$error("green_out exp %0d got %0d", e.green_out, out_data.green_out);
						errs++;
					end
					if (out_data.blue_out !== e.blue_out) begin
						$error("blue_out exp %0d got %0d", e.blue_out, out_data.blue_out);
						errs++;
					end
					if (out_data.last_pixel_out !== e.last_pixel_out) begin
						$error("last_pixel_out exp %0d got %0d", e.last_pixel_out,
							out_data.last_pixel_out);
						errs++;
					end
				end
			end
			fail_count <= fail_count + errs;
			pending_count <= expected_pixels.size();
		end
	end
endmodule

// ----- tb/tb_pixel_tone_mapper.sv -----
`timescale 1ns / 1ps

module tb_pixel_tone_mapper;

	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 20;
	// curve code with no curve of its own
	localparam logic [1:0] CURVE_SPARE = 2'd3;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	ptm_pkg::ptm_in_t  in_data = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	ptm_pkg::ptm_out_t out_data;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [1:0]        cfg_data = '0;
	int                fail_count;
	int                pending_count;
	int                idle_cycles = 0;
	int                burst_left = 0;
	int                gap_left = 0;
	int                stall_mode = 0;

	always #6 clk = ~clk;

	pixel_tone_mapper dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	ptm_checker chk (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.fail_count(fail_count), .pending_count(pending_count)
	);

	// receiver stall pattern; mode changes now and then
	always @(posedge clk) begin
		if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
		case (stall_mode)
			0: out_ready <= 1'b1;
			1: out_ready <= ($urandom_range(0, 3) != 0);
			2: out_ready <= ($urandom_range(0, 1) != 0);
			default: out_ready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// watchdog on cycles with no transfer
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
		input logic last);
		// bursty sender: random gaps between bursts
		if (burst_left == 0) begin
			gap_left = $urandom_range(0, 3) == 0 ? $urandom_range(1, 8) : 0;
			burst_left = $urandom_range(1, 40);
		end
		if (gap_left > 0) begin
			in_valid <= 1'b0;
			repeat (gap_left) @(posedge clk);
			gap_left = 0;
		end
		in_valid <= 1'b1;
		in_data <= '{red_in: r, green_in: g, blue_in: b, last_pixel: last};
		do @(posedge clk); while (!in_ready);
		burst_left--;
	endtask

	task automatic drain_pixels();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_curve(input logic [1:0] sel);
		drain_pixels();
		cfg_valid <= 1'b1;
		cfg_data <= sel;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	task automatic random_frame_run(input int count);
		logic [7:0] c[3];
		for (int i = 0; i < count; i++) begin
			for (int k = 0; k < 3; k++) begin
				case ($urandom_range(0, 5))
					0: c[k] = 8'($urandom_range(0, 3));
					1: c[k] = 8'($urandom_range(252, 255));
					default: c[k] = 8'($urandom);
				endcase
			end
			send_pixel(c[0], c[1], c[2], $urandom_range(0, 15) == 0);
		end
	endtask

	initial begin
		logic [1:0] sel_list[5];
		sel_list = '{ptm_pkg::CURVE_ACES, ptm_pkg::CURVE_REINHARD, ptm_pkg::CURVE_FILMIC,
			CURVE_SPARE, ptm_pkg::CURVE_ACES};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed extremes under the reset curve, then each curve
		for (int s = 0; s < 4; s++) begin
			if (s != 0) write_curve(sel_list[s]);
			send_pixel(8'd0, 8'd255, 8'd1, 1'b0);
			send_pixel(8'd255, 8'd0, 8'd170, 1'b1);
			send_pixel(8'd128, 8'd85, 8'd254, 1'b0);
			send_pixel(8'hAA, 8'h55, 8'h0F, 1'b1);
		end
		// random phases over all curve settings, including the unused code
		for (int s = 0; s < 5; s++) begin
			write_curve(sel_list[s]);
			random_frame_run(350);
		end
		drain_pixels();
		if (fail_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
